[rtl/core/lrat_pkg.sv]
// Shared constants and types of the limited rate aim tracker.
// Used by the front, the item queue, the back and the top level.
`timescale 1ns / 1ps

package lrat_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int PI_Q            = 12868;
    localparam int HALFPI_Q        = 6434;
    localparam int TWOPI_Q         = 2 * PI_Q;
    localparam int EPS_Q           = 41;
    localparam int TINY_Q          = 4;
    localparam int ONE_Q           = 4096;
    localparam int YAW_BOUND       = PI_Q - EPS_Q;
    localparam int PITCH_BOUND     = HALFPI_Q - EPS_Q;
    localparam int EPS_SQ          = EPS_Q * EPS_Q;
    localparam int REACH_SHIFT     = 24 - ANGLE_FRAC_BITS;

    localparam int QUEUE_DEPTH     = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_YAW_A   = 3'd0;
    localparam logic [2:0] REG_YAW_B   = 3'd1;
    localparam logic [2:0] REG_PITCH_A = 3'd2;
    localparam logic [2:0] REG_PITCH_B = 3'd3;
    localparam logic [2:0] REG_SPEED   = 3'd4;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic signed [14:0] cy;
        logic signed [13:0] cp;
        logic               in_box;
        logic [15:0]        et;
        logic [15:0]        speed;
        logic signed [14:0] ylo;
        logic signed [14:0] yhi;
        logic signed [13:0] plo;
        logic signed [13:0] phi;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_DX2,
        S_DY2,
        S_RR,
        S_CMP,
        S_SQRT,
        S_MULX,
        S_DIVX,
        S_MULY,
        S_DIVY,
        S_FINY,
        S_EXY,
        S_DIVEY,
        S_FINEY,
        S_EXP,
        S_DIVEP,
        S_FINEP,
        S_OUT
    } t_state;

endpackage

[rtl/core/lrat_front.sv]
// Front of the aim tracker: sorts and clamps the limits and constrains the target.
// Depends on lrat_pkg; feeds lrat_queue.
`timescale 1ns / 1ps

module lrat_front (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [14:0]   i_target_yaw,
    input  logic signed [13:0]   i_target_pitch,
    input  logic [15:0]          i_elapsed_time,
    input  logic signed [14:0]   i_yaw_a,
    input  logic signed [14:0]   i_yaw_b,
    input  logic signed [13:0]   i_pitch_a,
    input  logic signed [13:0]   i_pitch_b,
    input  logic [15:0]          i_speed,
    input  logic                 i_q_full,
    output logic                 o_push,
    output lrat_pkg::t_item      o_item
);

    logic signed [14:0] ymin, ymax, ylo, yhi;
    logic signed [13:0] pmin, pmax, plo, phi;
    logic signed [16:0] ty, dl, dr;
    logic signed [14:0] cy;
    logic signed [13:0] cp;
    logic               in_box;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        ymin = (i_yaw_a < i_yaw_b) ? i_yaw_a : i_yaw_b;
        ymax = (i_yaw_a < i_yaw_b) ? i_yaw_b : i_yaw_a;
        pmin = (i_pitch_a < i_pitch_b) ? i_pitch_a : i_pitch_b;
        pmax = (i_pitch_a < i_pitch_b) ? i_pitch_b : i_pitch_a;
        ylo = ymin;
        if (ymin < -15'(lrat_pkg::YAW_BOUND)) ylo = -15'(lrat_pkg::YAW_BOUND);
        if (ymin > 15'(lrat_pkg::YAW_BOUND))  ylo = 15'(lrat_pkg::YAW_BOUND);
        yhi = ymax;
        if (ymax < -15'(lrat_pkg::YAW_BOUND)) yhi = -15'(lrat_pkg::YAW_BOUND);
        if (ymax > 15'(lrat_pkg::YAW_BOUND))  yhi = 15'(lrat_pkg::YAW_BOUND);
        plo = pmin;
        if (pmin < -14'(lrat_pkg::PITCH_BOUND)) plo = -14'(lrat_pkg::PITCH_BOUND);
        if (pmin > 14'(lrat_pkg::PITCH_BOUND))  plo = 14'(lrat_pkg::PITCH_BOUND);
        phi = pmax;
        if (pmax < -14'(lrat_pkg::PITCH_BOUND)) phi = -14'(lrat_pkg::PITCH_BOUND);
        if (pmax > 14'(lrat_pkg::PITCH_BOUND))  phi = 14'(lrat_pkg::PITCH_BOUND);
    end

    always_comb begin
        in_box = 1'b1;
        cp = i_target_pitch;
        if (i_target_pitch < plo) begin
            in_box = 1'b0;
            cp = plo;
        end
        if (i_target_pitch > phi) begin
            in_box = 1'b0;
            cp = phi;
        end
        ty = 17'(i_target_yaw);
        cy = i_target_yaw;
        dl = '0;
        dr = '0;
        // Outside the yaw limits the yaw snaps to the nearer edge, measured across the wrap.
        if (i_target_yaw < ylo) begin
            dl = 17'(ylo) - ty;
            dr = ty + 17'(lrat_pkg::TWOPI_Q) - 17'(yhi);
            in_box = 1'b0;
            cy = (dl < dr) ? ylo : yhi;
        end
        if (i_target_yaw > yhi) begin
            dl = 17'(ylo) - ty + 17'(lrat_pkg::TWOPI_Q);
            dr = ty - 17'(yhi);
            in_box = 1'b0;
            cy = (dl < dr) ? ylo : yhi;
        end
    end

    always_comb begin
        o_item.cy     = cy;
        o_item.cp     = cp;
        o_item.in_box = in_box;
        o_item.et     = i_elapsed_time;
        o_item.speed  = i_speed;
        o_item.ylo    = ylo;
        o_item.yhi    = yhi;
        o_item.plo    = plo;
        o_item.phi    = phi;
    end

endmodule

[rtl/core/lrat_queue.sv]
// Short item queue between the front and the back of the aim tracker.
// Depends on lrat_pkg for the item type and depth.
`timescale 1ns / 1ps

module lrat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lrat_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lrat_pkg::t_item o_item
);

    lrat_pkg::t_item r_mem [lrat_pkg::QUEUE_DEPTH];
    logic            r_wp, r_rp;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'(lrat_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[rtl/core/lrat_back.sv]
// Back of the aim tracker: rate limited step, square root, divisions and extents.
// Depends on lrat_pkg; takes items from lrat_queue and holds the result register.
`timescale 1ns / 1ps

module lrat_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lrat_pkg::t_item      i_q_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [14:0]   o_aim_yaw,
    output logic signed [13:0]   o_aim_pitch,
    output logic signed [13:0]   o_extent_yaw,
    output logic signed [13:0]   o_extent_pitch,
    output logic                 o_on_target
);

    lrat_pkg::t_state   r_state, n_state;
    lrat_pkg::t_item    r_item;
    logic signed [15:0] r_cur_y, r_cur_p, r_ny, r_np;
    logic [31:0]        r_prod;
    logic [19:0]        r_reach;
    logic signed [16:0] r_dx, r_dy;
    logic [29:0]        r_dist2;
    logic [39:0]        r_rr;
    logic               r_reach_ok;
    logic [29:0]        r_sx, r_sr, r_sb;
    logic [14:0]        r_rem, r_den;
    logic [15:0]        r_sh, r_q;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic signed [13:0] r_ext_y, r_ext_p;
    logic               r_out_valid;

    // Control decoded from the state, the step counter and the distance comparisons.
    logic               load, last;
    logic               cmp_ok, cmp_tiny;

    // Shared divider step and square root step.
    logic [15:0]        dv_t;
    logic               dv_ge;
    logic [14:0]        dv_rem;
    logic [30:0]        sq_sum;
    logic               sq_ge;

    // Extent setup for the axis in work.
    logic signed [15:0] ex_p, ex_lo, ex_hi;
    logic signed [16:0] ex_w;
    logic signed [18:0] ex_num;
    logic [18:0]        ex_mag;
    logic               ex_tiny, ex_sat;
    logic signed [13:0] ex_sat_val;

    // Axis step products.
    logic [14:0]        ax_mag;
    logic [34:0]        ax_prod;
    logic signed [16:0] q_signed;

    assign last     = (r_cnt == 5'd0);
    assign cmp_ok   = {10'd0, r_dist2} < r_rr;
    assign cmp_tiny = r_dist2 < 30'(lrat_pkg::EPS_SQ);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lrat_pkg::S_IDLE:  if (i_q_valid && !r_out_valid) n_state = lrat_pkg::S_MUL;
            lrat_pkg::S_MUL:   n_state = lrat_pkg::S_DX2;
            lrat_pkg::S_DX2:   n_state = lrat_pkg::S_DY2;
            lrat_pkg::S_DY2:   n_state = lrat_pkg::S_RR;
            lrat_pkg::S_RR:    n_state = lrat_pkg::S_CMP;
            lrat_pkg::S_CMP:   n_state = (cmp_ok || cmp_tiny) ? lrat_pkg::S_EXY
                                                              : lrat_pkg::S_SQRT;
            lrat_pkg::S_SQRT:  if (last) n_state = lrat_pkg::S_MULX;
            lrat_pkg::S_MULX:  n_state = lrat_pkg::S_DIVX;
            lrat_pkg::S_DIVX:  if (last) n_state = lrat_pkg::S_MULY;
            lrat_pkg::S_MULY:  n_state = lrat_pkg::S_DIVY;
            lrat_pkg::S_DIVY:  if (last) n_state = lrat_pkg::S_FINY;
            lrat_pkg::S_FINY:  n_state = lrat_pkg::S_EXY;
            lrat_pkg::S_EXY:   n_state = (ex_tiny || ex_sat) ? lrat_pkg::S_EXP
                                                             : lrat_pkg::S_DIVEY;
            lrat_pkg::S_DIVEY: if (last) n_state = lrat_pkg::S_FINEY;
            lrat_pkg::S_FINEY: n_state = lrat_pkg::S_EXP;
            lrat_pkg::S_EXP:   n_state = (ex_tiny || ex_sat) ? lrat_pkg::S_OUT
                                                             : lrat_pkg::S_DIVEP;
            lrat_pkg::S_DIVEP: if (last) n_state = lrat_pkg::S_FINEP;
            lrat_pkg::S_FINEP: n_state = lrat_pkg::S_OUT;
            lrat_pkg::S_OUT:   n_state = lrat_pkg::S_IDLE;
            default:           n_state = lrat_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        load = 1'b0;
        case (r_state)
            lrat_pkg::S_IDLE: load = i_q_valid && !r_out_valid;
            default:          load = 1'b0;
        endcase
    end

    assign o_pop = load;

    always_comb begin
        dv_t   = {r_rem, r_sh[15]};
        dv_ge  = dv_t >= {1'b0, r_den};
        dv_rem = dv_ge ? 15'(dv_t - {1'b0, r_den}) : dv_t[14:0];
        sq_sum = {1'b0, r_sr} + {1'b0, r_sb};
        sq_ge  = {1'b0, r_sx} >= sq_sum;
    end

    always_comb begin
        if (r_state == lrat_pkg::S_EXY) begin
            ex_p  = r_ny;
            ex_lo = 16'(r_item.ylo);
            ex_hi = 16'(r_item.yhi);
        end else begin
            ex_p  = r_np;
            ex_lo = 16'(r_item.plo);
            ex_hi = 16'(r_item.phi);
        end
        ex_w       = 17'(ex_hi) - 17'(ex_lo);
        ex_num     = 19'(2 * (19'(ex_p) - 19'(ex_lo))) - 19'(ex_w);
        ex_mag     = ex_num[18] ? 19'(-ex_num) : 19'(ex_num);
        ex_tiny    = ex_w <= 17'(lrat_pkg::TINY_Q);
        // The quotient reaches one as soon as the numerator reaches the width.
        ex_sat     = ex_mag >= 19'(ex_w);
        ex_sat_val = ex_num[18] ? -14'(lrat_pkg::ONE_Q) : 14'(lrat_pkg::ONE_Q);
    end

    always_comb begin
        if (r_state == lrat_pkg::S_MULX) begin
            ax_mag = r_dx[16] ? 15'(-r_dx) : r_dx[14:0];
        end else begin
            ax_mag = r_dy[16] ? 15'(-r_dy) : r_dy[14:0];
        end
        ax_prod  = 35'(ax_mag) * 35'(r_reach);
        q_signed = r_neg ? -17'(r_q) : 17'(r_q);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lrat_pkg::S_IDLE: if (load) r_item <= i_q_item;
            lrat_pkg::S_MUL: begin
                r_prod <= 32'(r_item.speed) * 32'(r_item.et);
                r_dx   <= 17'(r_item.cy) - 17'(r_cur_y);
                r_dy   <= 17'(r_item.cp) - 17'(r_cur_p);
            end
            lrat_pkg::S_DX2: begin
                r_reach <= r_prod[31:lrat_pkg::REACH_SHIFT];
                r_dist2 <= 30'(34'(r_dx) * 34'(r_dx));
            end
            lrat_pkg::S_DY2: r_dist2 <= r_dist2 + 30'(34'(r_dy) * 34'(r_dy));
            lrat_pkg::S_RR:  r_rr <= 40'(r_reach) * 40'(r_reach);
            lrat_pkg::S_CMP: begin
                r_reach_ok <= cmp_ok;
                if (cmp_ok) begin
                    r_ny <= 16'(r_item.cy);
                    r_np <= 16'(r_item.cp);
                end else if (cmp_tiny) begin
                    r_ny <= r_cur_y;
                    r_np <= r_cur_p;
                end
                r_sx  <= r_dist2;
                r_sr  <= '0;
                r_sb  <= 30'(1) << 28;
                r_cnt <= 5'd14;
            end
            lrat_pkg::S_SQRT: begin
                if (sq_ge) begin
                    r_sx <= 30'({1'b0, r_sx} - sq_sum);
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb  <= r_sb >> 2;
                r_cnt <= r_cnt - 5'd1;
            end
            lrat_pkg::S_MULX, lrat_pkg::S_MULY: begin
                if (r_state == lrat_pkg::S_MULY) r_ny <= r_cur_y + 16'(q_signed);
                // The quotient stays below two to the sixteenth, so the top part
                // of the product is already a valid remainder.
                r_rem <= ax_prod[30:16];
                r_sh  <= ax_prod[15:0];
                r_den <= r_sr[14:0];
                r_q   <= '0;
                r_neg <= (r_state == lrat_pkg::S_MULX) ? r_dx[16] : r_dy[16];
                r_cnt <= 5'd15;
            end
            lrat_pkg::S_DIVX, lrat_pkg::S_DIVY, lrat_pkg::S_DIVEY, lrat_pkg::S_DIVEP: begin
                r_rem <= dv_rem;
                r_sh  <= r_sh << 1;
                r_q   <= {r_q[14:0], dv_ge};
                r_cnt <= r_cnt - 5'd1;
            end
            lrat_pkg::S_FINY: r_np <= r_cur_p + 16'(q_signed);
            lrat_pkg::S_EXY, lrat_pkg::S_EXP: begin
                if (ex_tiny) begin
                    if (r_state == lrat_pkg::S_EXY) r_ext_y <= '0;
                    else                            r_ext_p <= '0;
                end else if (ex_sat) begin
                    if (r_state == lrat_pkg::S_EXY) r_ext_y <= ex_sat_val;
                    else                            r_ext_p <= ex_sat_val;
                end
                r_rem <= ex_mag[14:0];
                r_sh  <= '0;
                r_den <= ex_w[14:0];
                r_q   <= '0;
                r_neg <= ex_num[18];
                r_cnt <= 5'(lrat_pkg::ANGLE_FRAC_BITS - 1);
            end
            lrat_pkg::S_FINEY: r_ext_y <= 14'(q_signed);
            lrat_pkg::S_FINEP: r_ext_p <= 14'(q_signed);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lrat_pkg::S_OUT) begin
            o_aim_yaw      <= r_ny[14:0];
            o_aim_pitch    <= r_np[13:0];
            o_extent_yaw   <= r_ext_y;
            o_extent_pitch <= r_ext_p;
            o_on_target    <= r_item.in_box && r_reach_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrat_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cur_y     <= '0;
            r_cur_p     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lrat_pkg::S_OUT) begin
                r_out_valid <= 1'b1;
                r_cur_y     <= r_ny;
                r_cur_p     <= r_np;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    // A new item only starts once the result register is empty.
    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lrat_pkg::S_IDLE && r_state != lrat_pkg::S_MUL) |-> !r_out_valid)
        else $error("back busy while a result beat is pending");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrat_pkg::S_DIVX || r_state == lrat_pkg::S_DIVY ||
         r_state == lrat_pkg::S_DIVEY || r_state == lrat_pkg::S_DIVEP) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_extent_yaw <= 14'(lrat_pkg::ONE_Q) &&
                         o_extent_yaw >= -14'(lrat_pkg::ONE_Q) &&
                         o_extent_pitch <= 14'(lrat_pkg::ONE_Q) &&
                         o_extent_pitch >= -14'(lrat_pkg::ONE_Q)))
        else $error("extent out of range");

endmodule

[rtl/core/limited_rate_aim_tracker.sv]
// Top level of the limited rate aim tracker: configuration registers and the
// front, queue and back. Depends on lrat_pkg, lrat_front, lrat_queue, lrat_back.
//
// Usage: an input beat (i_valid, o_stall) carries a target yaw, pitch and the
// elapsed time; it is accepted when i_valid is high and o_stall low. Each beat
// yields exactly one result beat (o_valid, i_stall) with the new aim, the
// extents within the limits and the on-target flag, taken when i_stall is low.
// The front clamps the target combinationally and writes a two-entry queue, so
// up to two beats are taken while the back works. The back handles one item at
// a time on a shared shift-subtract divider and a bit-serial square root.
// A target in reach or an aim that holds skips the root and the axis divisions; a
// partial step runs 15 root steps and two 16-step divisions. Each extent that is
// neither tiny nor saturated needs a 12-step division. Configuration writes
// (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and belong to idle
// periods only.
// Reset (synchronous, i_rst_n low) empties the queue, faces the aim forward,
// clears the limits and sets max_speed to two pi. While the receiver stalls,
// the result is held and the back waits; the queue then fills and o_stall rises.
`timescale 1ns / 1ps

module limited_rate_aim_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [14:0]  i_target_yaw,
    input  logic signed [13:0]  i_target_pitch,
    input  logic [15:0]         i_elapsed_time,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [14:0]  o_aim_yaw,
    output logic signed [13:0]  o_aim_pitch,
    output logic signed [13:0]  o_extent_yaw,
    output logic signed [13:0]  o_extent_pitch,
    output logic                o_on_target,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);

    logic signed [14:0] r_yaw_a, r_yaw_b;
    logic signed [13:0] r_pitch_a, r_pitch_b;
    logic [15:0]        r_speed;

    logic               push, pop, q_full, q_valid;
    lrat_pkg::t_item    f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_a   <= '0;
            r_yaw_b   <= '0;
            r_pitch_a <= '0;
            r_pitch_b <= '0;
            r_speed   <= 16'(lrat_pkg::TWOPI_Q);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrat_pkg::REG_YAW_A:   r_yaw_a   <= i_cfg_data[14:0];
                lrat_pkg::REG_YAW_B:   r_yaw_b   <= i_cfg_data[14:0];
                lrat_pkg::REG_PITCH_A: r_pitch_a <= i_cfg_data[13:0];
                lrat_pkg::REG_PITCH_B: r_pitch_b <= i_cfg_data[13:0];
                lrat_pkg::REG_SPEED:   r_speed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lrat_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_target_yaw   (i_target_yaw),
        .i_target_pitch (i_target_pitch),
        .i_elapsed_time (i_elapsed_time),
        .i_yaw_a        (r_yaw_a),
        .i_yaw_b        (r_yaw_b),
        .i_pitch_a      (r_pitch_a),
        .i_pitch_b      (r_pitch_b),
        .i_speed        (r_speed),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (f_item)
    );

    lrat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lrat_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_aim_yaw      (o_aim_yaw),
        .o_aim_pitch    (o_aim_pitch),
        .o_extent_yaw   (o_extent_yaw),
        .o_extent_pitch (o_extent_pitch),
        .o_on_target    (o_on_target)
    );

endmodule
